>>> src/cau_pkg.sv
// ----------------------------------------------------------------------------
// cau_pkg: shared types and helpers for the complex arithmetic unit
// Beat payloads, pipeline stage records, saturation and one restoring
// division step used by every cell of the divider row.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam int CAU_FRAC_BITS = 16;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } cau_op_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] a_re;
        logic signed [31:0] a_im;
        logic signed [31:0] b_re;
        logic signed [31:0] b_im;
    } cau_in_t;

    typedef struct packed {
        logic signed [31:0] res_re;
        logic signed [31:0] res_im;
        logic               overflow;
        logic               div_by_zero;
    } cau_out_t;

    // one divider lane: partial remainder, dividend bits left, quotient
    typedef struct packed {
        logic [63:0] rem;
        logic [63:0] dvd;
        logic [32:0] q;
        logic        big;
    } cau_lane_t;

    // side info riding along the divider row
    typedef struct packed {
        cau_out_t side;
        logic     is_div;
        logic     dz;
        logic     neg_re;
        logic     neg_im;
    } cau_tag_t;

    typedef struct packed {
        logic      valid;
        logic [63:0] den;
        cau_lane_t lane_re;
        cau_lane_t lane_im;
        cau_tag_t  tag;
    } cau_stage_t;

    typedef struct packed {
        logic signed [31:0] val;
        logic               ovf;
    } cau_sat_t;

    localparam logic signed [65:0] SAT_MAX = 66'sh0_7FFF_FFFF;
    localparam logic signed [65:0] SAT_MIN = -66'sh0_8000_0000;

    // clamp an exact value to the 32-bit range
    function automatic cau_sat_t cau_sat(input logic signed [65:0] v);
        cau_sat_t r;
        if (v > SAT_MAX) begin
            r.val = 32'sh7FFF_FFFF;
            r.ovf = 1'b1;
        end else if (v < SAT_MIN) begin
            r.val = 32'sh8000_0000;
            r.ovf = 1'b1;
        end else begin
            r.val = v[31:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    // one restoring step: bring in the next dividend bit, try a subtract
    function automatic cau_lane_t cau_div_step(input cau_lane_t l, input logic [63:0] den);
        cau_lane_t   r;
        logic [64:0] r2;
        r2    = {l.rem, l.dvd[63]};
        r.dvd = {l.dvd[62:0], 1'b0};
        r.big = l.big | l.q[32];
        r.q   = {l.q[31:0], 1'b0};
        r.rem = r2[63:0];
        if (r2 >= {1'b0, den}) begin
            r.rem  = 64'(r2 - {1'b0, den});
            r.q[0] = 1'b1;
        end
        return r;
    endfunction

endpackage

>>> src/cau_div_cell.sv
// ----------------------------------------------------------------------------
// cau_div_cell: one cell of the divider row
// Produces one quotient bit for both lanes and hands the record on.
// ----------------------------------------------------------------------------
module cau_div_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  cau_pkg::cau_stage_t stage_in,
    output cau_pkg::cau_stage_t stage_out
);
    import cau_pkg::*;

    cau_stage_t stage_reg;
    cau_stage_t stage_next;

    // step both lanes against the shared divisor
    always_comb begin
        stage_next         = stage_in;
        stage_next.lane_re = cau_div_step(stage_in.lane_re, stage_in.den);
        stage_next.lane_im = cau_div_step(stage_in.lane_im, stage_in.den);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            stage_reg.valid <= 1'b0;
        end else if (en) begin
            stage_reg <= stage_next;
        end
    end

    assign stage_out = stage_reg;

endmodule

>>> src/complex_arith_unit_top.sv
// ----------------------------------------------------------------------------
// complex_arith_unit_top: pipelined complex add/sub/mul/div, signed fixed point
// Takes one beat per clock unless stalled; one result per beat, in order.
// ----------------------------------------------------------------------------
// Operands are Q16.16 at the default FRAC_BITS. The path: a register of six
// 32x32 multipliers, a register of sums and rescaling, 64 + FRAC_BITS divider
// cells of one quotient bit each, and the output register. Every operation
// takes the same path, so results leave in order. Throughput is one beat per
// cycle; the whole pipeline holds while a result waits at the output.
module complex_arith_unit_top #(
    parameter int FRAC_BITS = cau_pkg::CAU_FRAC_BITS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  cau_pkg::cau_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output cau_pkg::cau_out_t m_data
);
    import cau_pkg::*;

    localparam int NCELL = 64 + FRAC_BITS;

    logic adv;

    // product stage
    logic               a_vld_reg;
    logic [1:0]         a_kind_reg;
    logic signed [63:0] p_rr_reg, p_ii_reg, p_ri_reg, p_ir_reg;
    logic signed [63:0] p_bb_re_reg, p_bb_im_reg;
    logic signed [32:0] sr_reg, si_reg;

    // divider row
    cau_stage_t chain [0:NCELL];
    cau_stage_t head_reg, head_next;

    cau_out_t out_reg, out_next;
    logic     out_vld_reg;

    assign adv     = !out_vld_reg || m_ready;
    assign s_ready = adv;

    // multiply and add/subtract
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_vld_reg <= 1'b0;
        end else if (adv) begin
            a_vld_reg   <= s_valid;
            a_kind_reg  <= s_data.kind;
            p_rr_reg    <= 64'(s_data.a_re) * 64'(s_data.b_re);
            p_ii_reg    <= 64'(s_data.a_im) * 64'(s_data.b_im);
            p_ri_reg    <= 64'(s_data.a_re) * 64'(s_data.b_im);
            p_ir_reg    <= 64'(s_data.a_im) * 64'(s_data.b_re);
            p_bb_re_reg <= 64'(s_data.b_re) * 64'(s_data.b_re);
            p_bb_im_reg <= 64'(s_data.b_im) * 64'(s_data.b_im);
            sr_reg      <= (s_data.kind == OP_SUB) ? 33'(s_data.a_re) - 33'(s_data.b_re)
                                                   : 33'(s_data.a_re) + 33'(s_data.b_re);
            si_reg      <= (s_data.kind == OP_SUB) ? 33'(s_data.a_im) - 33'(s_data.b_im)
                                                   : 33'(s_data.a_im) + 33'(s_data.b_im);
        end
    end

    // sums, rescale, divider setup
    always_comb begin
        logic signed [65:0] pr, pi, nr, ni;
        cau_sat_t           s_re, s_im;
        pr = 66'(p_rr_reg) - 66'(p_ii_reg);
        pi = 66'(p_ri_reg) + 66'(p_ir_reg);
        nr = 66'(p_rr_reg) + 66'(p_ii_reg);
        ni = 66'(p_ir_reg) - 66'(p_ri_reg);
        if (a_kind_reg == OP_MUL) begin
            s_re = cau_sat(pr >>> FRAC_BITS);
            s_im = cau_sat(pi >>> FRAC_BITS);
        end else begin
            s_re = cau_sat(66'(sr_reg));
            s_im = cau_sat(66'(si_reg));
        end
        head_next.valid            = a_vld_reg;
        head_next.den              = $unsigned(p_bb_re_reg) + $unsigned(p_bb_im_reg);
        head_next.lane_re.rem      = '0;
        head_next.lane_re.q        = '0;
        head_next.lane_re.big      = 1'b0;
        head_next.lane_re.dvd      = (nr < 0) ? 64'(-nr) : 64'(nr);
        head_next.lane_im.rem      = '0;
        head_next.lane_im.q        = '0;
        head_next.lane_im.big      = 1'b0;
        head_next.lane_im.dvd      = (ni < 0) ? 64'(-ni) : 64'(ni);
        head_next.tag.side.res_re  = s_re.val;
        head_next.tag.side.res_im  = s_im.val;
        head_next.tag.side.overflow    = s_re.ovf | s_im.ovf;
        head_next.tag.side.div_by_zero = 1'b0;
        head_next.tag.is_div       = (a_kind_reg == OP_DIV);
        head_next.tag.dz           = (head_next.den == '0);
        head_next.tag.neg_re       = (nr < 0);
        head_next.tag.neg_im       = (ni < 0);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg.valid <= 1'b0;
        end else if (adv) begin
            head_reg <= head_next;
        end
    end

    assign chain[0] = head_reg;

    // row of division cells, one quotient bit each
    for (genvar k = 0; k < NCELL; k++) begin : g_cell
        cau_div_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (adv),
            .stage_in (chain[k]),
            .stage_out(chain[k+1])
        );
    end

    // quotient sign, saturation and result select
    always_comb begin
        cau_stage_t         t;
        logic [32:0]        qv_re, qv_im;
        logic signed [65:0] v_re, v_im;
        cau_sat_t           d_re, d_im;
        t     = chain[NCELL];
        qv_re = t.lane_re.big ? 33'h1_0000_0000 : t.lane_re.q;
        qv_im = t.lane_im.big ? 33'h1_0000_0000 : t.lane_im.q;
        v_re  = $signed({33'b0, qv_re});
        v_im  = $signed({33'b0, qv_im});
        if (t.tag.neg_re) begin
            v_re = -v_re;
        end
        if (t.tag.neg_im) begin
            v_im = -v_im;
        end
        d_re = cau_sat(v_re);
        d_im = cau_sat(v_im);
        if (!t.tag.is_div) begin
            out_next = t.tag.side;
        end else if (t.tag.dz) begin
            out_next.res_re      = '0;
            out_next.res_im      = '0;
            out_next.overflow    = 1'b0;
            out_next.div_by_zero = 1'b1;
        end else begin
            out_next.res_re      = d_re.val;
            out_next.res_im      = d_im.val;
            out_next.overflow    = d_re.ovf | d_im.ovf;
            out_next.div_by_zero = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (adv) begin
            out_vld_reg <= chain[NCELL].valid;
            out_reg     <= out_next;
        end
    end

    assign m_valid = out_vld_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // a zero divisor beat carries a clean zero result
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.div_by_zero |-> m_data.res_re == 0 && m_data.res_im == 0
            && !m_data.overflow)
        else $error("div_by_zero beat with nonzero result");

    // overflow only with a part at a rail
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.overflow |->
            m_data.res_re == 32'sh7FFF_FFFF || m_data.res_re == 32'sh8000_0000 ||
            m_data.res_im == 32'sh7FFF_FFFF || m_data.res_im == 32'sh8000_0000)
        else $error("overflow flagged without saturated part");

    // an accepted beat enters the product stage
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> a_vld_reg)
        else $error("accepted beat lost at product stage");
`endif

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb: self-checking testbench for complex_arith_unit_top
// Drives operand beats with random gaps, predicts each result in the bench
// and compares every result beat, in order, against the predicted one.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import cau_pkg::*;

    localparam int FB        = CAU_FRAC_BITS;
    localparam int LATENCY   = 67 + FB;
    localparam int N_RANDOM  = 450;
    localparam int MAX_CYC   = 400000;

    logic     aclk = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    cau_in_t  s_data = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    cau_out_t m_data;

    complex_arith_unit_top DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    cau_out_t pending_results[$];
    int       n_errors = 0;
    int       n_results = 0;
    int       n_sent = 0;
    int       n_ovf = 0;
    int       n_dz = 0;
    longint   cycle = 0;
    bit       sending_done = 1'b0;

    // clamp a wide signed value to 32 bits
    function automatic void clamp32(input logic signed [127:0] v,
                                    output logic signed [31:0] r, inout logic ovf);
        if (v > 128'sh7FFF_FFFF) begin
            r = 32'sh7FFF_FFFF; ovf = 1'b1;
        end else if (v < -128'sh8000_0000) begin
            r = 32'sh8000_0000; ovf = 1'b1;
        end else begin
            r = v[31:0];
        end
    endfunction

    // quotient num * 2^FB / den, truncated toward zero
    function automatic logic signed [127:0] quot(input logic signed [127:0] num,
                                                 input logic signed [127:0] den);
        logic signed [127:0] mag;
        logic signed [127:0] q;
        mag = (num < 0) ? -num : num;
        q   = (mag <<< FB) / den;
        return (num < 0) ? -q : q;
    endfunction

    function automatic cau_out_t predict_complex(input cau_in_t x);
        cau_out_t r;
        logic signed [127:0] ar, ai, br, bi, pr, pi, den;
        logic ovf;
        ar = x.a_re; ai = x.a_im; br = x.b_re; bi = x.b_im;
        ovf = 1'b0;
        r = '0;
        case (cau_op_t'(x.kind))
            OP_ADD: begin
                pr = ar + br; pi = ai + bi;
            end
            OP_SUB: begin
                pr = ar - br; pi = ai - bi;
            end
            OP_MUL: begin
                pr = (ar * br - ai * bi) >>> FB;
                pi = (ar * bi + ai * br) >>> FB;
            end
            default: begin
                den = br * br + bi * bi;
                if (den == 0) begin
                    r.div_by_zero = 1'b1;
                    return r;
                end
                pr = quot(ar * br + ai * bi, den);
                pi = quot(ai * br - ar * bi, den);
            end
        endcase
        clamp32(pr, r.res_re, ovf);
        clamp32(pi, r.res_im, ovf);
        r.overflow = ovf;
        return r;
    endfunction

    function automatic logic [31:0] rand_operand();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3, 4: return 32'($signed($urandom_range(0, 32'h3_FFFF)) - 32'sh2_0000);
            5, 6: return 32'($signed($urandom_range(0, 32'h1FF_FFFF)) - 32'sh100_0000);
            default: return $urandom();
        endcase
    endfunction

    // one input beat, with a random gap ahead of it
    task automatic send_beat(input cau_in_t x);
        int gap;
        gap = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 2) : $urandom_range(0, 20);
        if ($urandom_range(0, 3) == 0) gap = 0;
        repeat (gap) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= x;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results.push_back(predict_complex(x));
        n_sent++;
        @(negedge aclk);
    endtask

    // directed rows: expected typed in where obvious, otherwise predictor
    typedef struct {
        cau_in_t  stim;
        bit       has_exp;
        cau_out_t exp_val;
    } row_t;

    row_t rows[$];

    function automatic cau_in_t mk(input cau_op_t k, input logic [31:0] a, b, c, d);
        cau_in_t x;
        x.kind = k; x.a_re = a; x.a_im = b; x.b_re = c; x.b_im = d;
        return x;
    endfunction

    function automatic cau_out_t mo(input logic [31:0] re, im, input logic ov, dz);
        cau_out_t o;
        o.res_re = re; o.res_im = im; o.overflow = ov; o.div_by_zero = dz;
        return o;
    endfunction

    initial begin
        row_t rw;
        cau_in_t x;
        rows.push_back('{mk(OP_ADD, 0, 0, 0, 0), 1, mo(0, 0, 0, 0)});
        rows.push_back('{mk(OP_ADD, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'hFFFF_FFFF),
                         1, mo(32'h7FFF_FFFF, 32'h8000_0000, 1, 0)});
        rows.push_back('{mk(OP_SUB, 32'h8000_0000, 32'h7FFF_FFFF, 1, 32'hFFFF_FFFF),
                         1, mo(32'h8000_0000, 32'h7FFF_FFFF, 1, 0)});
        rows.push_back('{mk(OP_SUB, 5, 7, 5, 7), 1, mo(0, 0, 0, 0)});
        rows.push_back('{mk(OP_MUL, 32'h1_0000, 32'h0, 32'h2_0000, 32'h3_0000),
                         1, mo(32'h2_0000, 32'h3_0000, 0, 0)});
        rows.push_back('{mk(OP_MUL, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000), 1, mo(0, 32'h7FFF_FFFF, 1, 0)});
        rows.push_back('{mk(OP_MUL, 32'hFFFF_FFFF, 0, 1, 0), 1,
                         mo(32'hFFFF_FFFF, 0, 0, 0)});
        rows.push_back('{mk(OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                            32'h7FFF_FFFF), 0, '0});
        rows.push_back('{mk(OP_DIV, 32'h1234_5678, 32'h8000_0000, 0, 0), 1,
                         mo(0, 0, 0, 1)});
        rows.push_back('{mk(OP_DIV, 32'h2_0000, 32'h4_0000, 32'h1_0000, 0), 1,
                         mo(32'h2_0000, 32'h4_0000, 0, 0)});
        rows.push_back('{mk(OP_DIV, 32'hFFFF_FFFF, 0, 32'h3_0000, 0), 0, '0});
        rows.push_back('{mk(OP_DIV, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0), 1,
                         mo(32'h7FFF_FFFF, 32'h8000_0000, 1, 0)});
        rows.push_back('{mk(OP_DIV, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                            32'h8000_0000), 0, '0});
        rows.push_back('{mk(OP_DIV, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                            32'h8000_0000), 0, '0});
        rows.push_back('{mk(OP_DIV, 5, 0, 0, 1), 0, '0});

        repeat (5) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        foreach (rows[i]) begin
            rw = rows[i];
            if (rw.has_exp && rw.exp_val != predict_complex(rw.stim)) begin
                $display("directed row %0d: table entry disagrees with prediction", i);
                n_errors++;
            end
            send_beat(rw.stim);
        end
        // random part: small operands (most often), extremes and full-range
        repeat (N_RANDOM) begin
            x.kind = 2'($urandom_range(0, 3));
            x.a_re = rand_operand(); x.a_im = rand_operand();
            x.b_re = rand_operand(); x.b_im = rand_operand();
            if (x.kind == OP_DIV && $urandom_range(0, 15) == 0) begin
                x.b_re = 0; x.b_im = 0;
            end
            send_beat(x);
        end
        s_valid <= 1'b0;
        sending_done = 1'b1;
    end

    // result side: random stalls, sampled at the rising edge
    initial begin
        int stall;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                stall--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
                if ($urandom_range(0, 9) < 2)
                    stall = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                       : $urandom_range(5, 40);
            end
        end
    end

    always @(posedge aclk) begin
        cau_out_t want;
        cycle <= cycle + 1;
        if (aresetn && m_valid && m_ready) begin
            n_results++;
            if (pending_results.size() == 0) begin
                n_errors++;
                if (n_errors <= 10) $display("unexpected result beat: %p", m_data);
            end else begin
                want = pending_results.pop_front();
                if (m_data.overflow) n_ovf++;
                if (m_data.div_by_zero) n_dz++;
                if (m_data !== want) begin
                    n_errors++;
                    if (n_errors <= 10)
                        $display("mismatch beat %0d: re %h/%h im %h/%h ovf %b/%b dz %b/%b",
                                 n_results, want.res_re, m_data.res_re, want.res_im,
                                 m_data.res_im, want.overflow, m_data.overflow,
                                 want.div_by_zero, m_data.div_by_zero);
                end
            end
        end
    end

    // end of run
    initial begin
        wait (sending_done);
        while (pending_results.size() != 0 && cycle < MAX_CYC) @(posedge aclk);
        repeat (LATENCY + 20) @(posedge aclk);
        if (pending_results.size() != 0) begin
            $display("%0d results never arrived", pending_results.size());
            n_errors++;
        end
        $display("%0d beats in, %0d results out", n_sent, n_results);
        $display("%0d saturated, %0d zero divisors, %0d errors", n_ovf, n_dz, n_errors);
        if (n_errors == 0) begin
            $display("tb: done, clean");
        end else begin
            $display("tb: done, errors");
        end
        $finish;
    end

    initial begin
        wait (cycle >= MAX_CYC);
        $display("timeout at cycle %0d", cycle);
        $display("tb: done, errors");
        $finish;
    end

endmodule

>>> files.f
src/cau_pkg.sv
src/cau_div_cell.sv
src/complex_arith_unit_top.sv
tb/tb.sv
